/* rtl/glr_pkg.sv */
package glr_pkg;

  // Default grid dimension for the clamp ceiling
  localparam int GRID_DIM_DEF = 64;

  // Field widths
  localparam int IN_W     = 7;
  localparam int COORD_W  = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W  = 12;
  localparam int PROD_W   = 14;
  localparam int TERM_W   = 9;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // Starting point and decision terms of one segment walk
  typedef struct packed {
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic signed [TERM_W-1:0] p;
    logic signed [TERM_W-1:0] a;
    logic signed [TERM_W-1:0] b;
    logic                     steep;
    logic                     y_down;
    logic [COORD_W-1:0]       count;
  } walk_init_t;

endpackage

/* rtl/glr_prep.sv */
module glr_prep #(
  parameter int GRID_DIM = glr_pkg::GRID_DIM_DEF
) (
  input  logic signed [glr_pkg::IN_W-1:0] start_x,
  input  logic signed [glr_pkg::IN_W-1:0] start_y,
  input  logic signed [glr_pkg::IN_W-1:0] end_x,
  input  logic signed [glr_pkg::IN_W-1:0] end_y,
  output glr_pkg::walk_init_t             init
);

  localparam int COORD_MAX = (1 << glr_pkg::COORD_W) - 1;
  localparam int CLAMP_I   = (GRID_DIM - 1 < COORD_MAX) ? GRID_DIM - 1 : COORD_MAX;
  localparam logic [glr_pkg::COORD_W-1:0] CLAMP_MAX = glr_pkg::COORD_W'(CLAMP_I);

  function automatic logic [glr_pkg::COORD_W-1:0] clamp(
    input logic signed [glr_pkg::IN_W-1:0] v
  );
    if (v[glr_pkg::IN_W-1]) begin
      return '0;
    end else if (v[glr_pkg::COORD_W-1:0] > CLAMP_MAX) begin
      return CLAMP_MAX;
    end else begin
      return v[glr_pkg::COORD_W-1:0];
    end
  endfunction

  logic                       swap;
  logic [glr_pkg::COORD_W-1:0] x0, y0, x1, y1;
  logic [glr_pkg::COORD_W-1:0] dx, dy, maj, mnr;
  logic                       y_down, steep;
  logic signed [glr_pkg::TERM_W-1:0] a_term, maj2, maj1;

  // Order endpoints so the column rises, then clamp
  always_comb begin
    swap = end_x < start_x;
    x0 = swap ? clamp(end_x)   : clamp(start_x);
    y0 = swap ? clamp(end_y)   : clamp(start_y);
    x1 = swap ? clamp(start_x) : clamp(end_x);
    y1 = swap ? clamp(start_y) : clamp(end_y);
  end

  // Deltas, major axis and initial decision terms
  always_comb begin
    y_down = y1 < y0;
    dx     = x1 - x0;
    dy     = y_down ? (y0 - y1) : (y1 - y0);
    steep  = (dx == '0) || (dy > dx);
    maj    = steep ? dy : dx;
    mnr    = steep ? dx : dy;
    a_term = {2'b00, mnr, 1'b0};
    maj2   = {2'b00, maj, 1'b0};
    maj1   = {3'b000, maj};
    init.x      = x0;
    init.y      = y0;
    init.a      = a_term;
    init.b      = a_term - maj2;
    init.p      = a_term - maj1;
    init.steep  = steep;
    init.y_down = y_down;
    init.count  = maj;
  end

endmodule

/* rtl/glr_walk.sv */
module glr_walk (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         advance,
  input  glr_pkg::walk_init_t          init,
  output logic [glr_pkg::COORD_W-1:0]  x,
  output logic [glr_pkg::COORD_W-1:0]  y,
  output logic                         last_step
);

  logic signed [glr_pkg::TERM_W-1:0] p, a, b, term, p_next;
  logic                             steep, y_down, minor;
  logic [glr_pkg::COORD_W-1:0]      count, y_step;

  // Shared decision-term adder: add b on a minor step, a otherwise
  always_comb begin
    minor  = !p[glr_pkg::TERM_W-1];
    term   = minor ? b : a;
    p_next = p + term;
    y_step = y_down ? (y - 6'd1) : (y + 6'd1);
  end

  assign last_step = (count == 6'd1);

  // Load a new segment or advance one cell along the major axis
  always_ff @(posedge clk) begin
    if (load) begin
      x      <= init.x;
      y      <= init.y;
      p      <= init.p;
      a      <= init.a;
      b      <= init.b;
      steep  <= init.steep;
      y_down <= init.y_down;
      count  <= init.count;
    end else if (advance) begin
      count <= count - 6'd1;
      p     <= p_next;
      if (steep) begin
        y <= y_step;
        if (minor) begin
          x <= x + 6'd1;
        end
      end else begin
        x <= x + 6'd1;
        if (minor) begin
          y <= y_step;
        end
      end
    end
  end

endmodule

/* rtl/grid_line_rasterizer_core.sv */
// Grid line rasterizer: walks a wall segment cell by cell (Bresenham).
// Input: pulse start with the four endpoint coordinates while busy is low;
// the item is taken at that edge. Endpoints are ordered by column, clamped
// to the grid, and the cells from the first endpoint up to but not
// including the second come out one per cycle.
// Output: cell_strobe marks each cell beat for one cycle, with cell_col,
// cell_row, cell_index (row * width + column), in_bounds and last.
// Timing: the walk registers load at the accepting edge and the output
// beat register takes each cell from them. A segment of n cells keeps
// busy high while it walks, and the next item is taken only once busy
// drops again, n at most 63. The rate is set by the single decision-term
// adder, which advances one cell per cycle.
// A zero-length segment produces no cells and busy stays low.
// Configuration: cfg_valid/cfg_ready write grid_width (index 0) or
// grid_height (index 1); cfg_ready is always high. Write only while idle.
// Reset: rst (synchronous) returns to idle and restores a 64 x 64 grid.
// The receiver has no back-pressure: every cell beat must be taken.
module grid_line_rasterizer_core #(
  parameter int GRID_DIM = glr_pkg::GRID_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [glr_pkg::IN_W-1:0]     start_x,
  input  logic signed [glr_pkg::IN_W-1:0]     start_y,
  input  logic signed [glr_pkg::IN_W-1:0]     end_x,
  input  logic signed [glr_pkg::IN_W-1:0]     end_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [glr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [glr_pkg::CFG_W-1:0]           cfg_data,
  output logic                                cell_strobe,
  output logic [glr_pkg::COORD_W-1:0]         cell_col,
  output logic [glr_pkg::COORD_W-1:0]         cell_row,
  output logic [glr_pkg::INDEX_W-1:0]         cell_index,
  output logic                                in_bounds,
  output logic                                last
);

  glr_pkg::state_t     state, state_next;
  glr_pkg::walk_init_t init;
  logic [glr_pkg::CFG_W-1:0]   grid_width, grid_height;
  logic                        accept, advance, last_step;
  logic [glr_pkg::COORD_W-1:0] wx, wy;
  logic [glr_pkg::PROD_W-1:0]  idx_full, lim;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= glr_pkg::GRID_RESET;
      grid_height <= glr_pkg::GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == glr_pkg::REG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end else if (cfg_index == glr_pkg::REG_GRID_HEIGHT) begin
        grid_height <= cfg_data;
      end
    end
  end

  glr_prep #(
    .GRID_DIM (GRID_DIM)
  ) u_prep (
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .init    (init)
  );

  glr_walk u_walk (
    .clk       (clk),
    .load      (accept),
    .advance   (advance),
    .init      (init),
    .x         (wx),
    .y         (wy),
    .last_step (last_step)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: skip the walk for a zero-length segment
  always_comb begin
    state_next = state;
    unique case (state)
      glr_pkg::ST_IDLE: begin
        if (accept && (init.count != '0)) begin
          state_next = glr_pkg::ST_WALK;
        end
      end
      glr_pkg::ST_WALK: begin
        if (last_step) begin
          state_next = glr_pkg::ST_IDLE;
        end
      end
      default: state_next = glr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy    = 1'b0;
    advance = 1'b0;
    unique case (state)
      glr_pkg::ST_IDLE: begin
        busy    = 1'b0;
        advance = 1'b0;
      end
      glr_pkg::ST_WALK: begin
        busy    = 1'b1;
        advance = 1'b1;
      end
      default: begin
        busy    = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  // Linear index and bounds limit
  always_comb begin
    idx_full = glr_pkg::PROD_W'(grid_width) * glr_pkg::PROD_W'(wy) + glr_pkg::PROD_W'(wx);
    lim      = glr_pkg::PROD_W'(grid_width) * glr_pkg::PROD_W'(grid_height);
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_strobe <= 1'b0;
    end else begin
      cell_strobe <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_col   <= wx;
      cell_row   <= wy;
      cell_index <= idx_full[glr_pkg::INDEX_W-1:0];
      in_bounds  <= idx_full < lim;
      last       <= last_step;
    end
  end

endmodule

/* rtl/glr_checker.sv */
module glr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cell_strobe,
  input logic last
);

  // Reset leaves the block idle with no beat pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !cell_strobe))
    else $error("block not idle after reset");

  // Cells of one segment arrive in consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (cell_strobe && !last) |=> cell_strobe)
    else $error("gap inside a segment");

  // Busy covers every beat except the closing one
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    (cell_strobe && !last) |-> busy)
    else $error("busy dropped mid segment");

  // The closing beat coincides with ready for the next item
  a_ready_on_last: assert property (@(posedge clk) disable iff (rst)
    (cell_strobe && last) |-> !busy)
    else $error("busy still high on final cell");

  // No beat in the cycle right after an accept
  a_first_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !cell_strobe)
    else $error("cell beat too early after accept");

endmodule

bind grid_line_rasterizer_core glr_checker u_glr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cell_strobe (cell_strobe),
  .last        (last)
);

/* tb/sv/grid_line_rasterizer_core_checker.sv */
`timescale 1ns / 1ps

module grid_line_rasterizer_core_checker
  import glr_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic signed [IN_W-1:0]      start_x,
  input  logic signed [IN_W-1:0]      start_y,
  input  logic signed [IN_W-1:0]      end_x,
  input  logic signed [IN_W-1:0]      end_y,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        cell_strobe,
  input  logic [COORD_W-1:0]          cell_col,
  input  logic [COORD_W-1:0]          cell_row,
  input  logic [INDEX_W-1:0]          cell_index,
  input  logic                        in_bounds,
  input  logic                        last,
  output int                          fail_count,
  output int                          cells_pending
);

  localparam int MAX_CELLS = 64;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [INDEX_W-1:0] index;
    logic               inb;
    logic               last;
  } cell_t;

  cell_t            pending_cells[$];
  logic [CFG_W-1:0] grid_w = GRID_RESET;
  logic [CFG_W-1:0] grid_h = GRID_RESET;
  int               mismatches = 0;

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > GRID_DIM - 1) return GRID_DIM - 1;
    return v;
  endfunction

  // Queue one cell; the bounds test uses the full index, the port keeps low bits
  function automatic void push_cell(int x, int y);
    int    idx;
    int    lim;
    cell_t c;
    idx     = int'(grid_w) * y + x;
    lim     = int'(grid_w) * int'(grid_h);
    c.col   = x[COORD_W-1:0];
    c.row   = y[COORD_W-1:0];
    c.index = idx[INDEX_W-1:0];
    c.inb   = (idx < lim);
    c.last  = 1'b0;
    pending_cells.push_back(c);
  endfunction

  // Walk one segment and queue every cell it covers, end point excluded
  function automatic void walk_segment(logic signed [IN_W-1:0] sx, logic signed [IN_W-1:0] sy,
                                       logic signed [IN_W-1:0] ex, logic signed [IN_W-1:0] ey);
    int    x0, y0, x1, y1;
    int    dx, dy, ystep, a, b, p, x, y, n;
    cell_t c;
    // order by signed column; equal columns keep the given order
    if (ex >= sx) begin
      x0 = clamp_coord(int'(sx)); y0 = clamp_coord(int'(sy));
      x1 = clamp_coord(int'(ex)); y1 = clamp_coord(int'(ey));
    end else begin
      x0 = clamp_coord(int'(ex)); y0 = clamp_coord(int'(ey));
      x1 = clamp_coord(int'(sx)); y1 = clamp_coord(int'(sy));
    end
    ystep = (y1 >= y0) ? 1 : -1;
    dx    = x1 - x0;
    dy    = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    x     = x0;
    y     = y0;
    n     = 0;
    if (dx == 0) begin
      while (y != y1 && n < MAX_CELLS) begin
        push_cell(x, y); n++; y += ystep;
      end
    end else if (dy == 0) begin
      while (x != x1 && n < MAX_CELLS) begin
        push_cell(x, y); n++; x += 1;
      end
    end else if (dy <= dx) begin
      // shallow: one column per cell
      a = 2 * dy;
      b = a - 2 * dx;
      p = a - dx;
      while (x < x1 && n < MAX_CELLS) begin
        push_cell(x, y); n++;
        if (p >= 0) begin
          y += ystep; p += b;
        end else begin
          p += a;
        end
        x += 1;
      end
    end else begin
      // steep: one row per cell
      a = 2 * dx;
      b = a - 2 * dy;
      p = a - dy;
      while (y != y1 && n < MAX_CELLS) begin
        push_cell(x, y); n++;
        if (p >= 0) begin
          x += 1; p += b;
        end else begin
          p += a;
        end
        y += ystep;
      end
    end
    // flag the final cell of the segment
    if (n > 0) begin
      c = pending_cells[pending_cells.size() - 1];
      c.last = 1'b1;
      pending_cells[pending_cells.size() - 1] = c;
    end
  endfunction

  task automatic report_cell(string what, cell_t want, cell_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected col %0d row %0d index %0d inb %0b last %0b, got col %0d row %0d index %0d inb %0b last %0b",
               $realtime, what, want.col, want.row, want.index, want.inb, want.last,
               got.col, got.row, got.index, got.inb, got.last);
    end
  endtask

  // Compare cell beats, predict accepted segments, track register writes
  always @(posedge clk) begin
    cell_t got;
    cell_t want;
    if (rst) begin
      grid_w = GRID_RESET;
      grid_h = GRID_RESET;
      pending_cells.delete();
    end else begin
      if (cell_strobe) begin
        got = '{col: cell_col, row: cell_row, index: cell_index, inb: in_bounds, last: last};
        if (pending_cells.size() == 0) begin
          report_cell("cell beat with nothing pending", '0, got);
        end else begin
          want = pending_cells.pop_front();
          if (got.col !== want.col || got.row !== want.row || got.index !== want.index ||
              got.inb !== want.inb || got.last !== want.last) begin
            report_cell("cell mismatch", want, got);
          end
        end
      end
      if (start && !busy) begin
        walk_segment(start_x, start_y, end_x, end_y);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH: begin
            grid_w = cfg_data;
          end
          REG_GRID_HEIGHT: begin
            grid_h = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count    <= mismatches;
    cells_pending <= pending_cells.size();
  end

endmodule

/* tb/sv/grid_line_rasterizer_core_tb.sv */
`timescale 1ns / 1ps

module grid_line_rasterizer_core_tb;
  import glr_pkg::*;

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 77;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  start_x = '0;
  logic signed [IN_W-1:0]  start_y = '0;
  logic signed [IN_W-1:0]  end_x = '0;
  logic signed [IN_W-1:0]  end_y = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    cell_strobe;
  logic [COORD_W-1:0]      cell_col;
  logic [COORD_W-1:0]      cell_row;
  logic [INDEX_W-1:0]      cell_index;
  logic                    in_bounds;
  logic                    last;
  int                      fail_count;
  int                      cells_pending;

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("grid_line_rasterizer_core_tb: done, errors");
    $finish;
  end

  grid_line_rasterizer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_strobe (cell_strobe),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .cell_index  (cell_index),
    .in_bounds   (in_bounds),
    .last        (last)
  );

  grid_line_rasterizer_core_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_strobe   (cell_strobe),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .cell_index    (cell_index),
    .in_bounds     (in_bounds),
    .last          (last),
    .fail_count    (fail_count),
    .cells_pending (cells_pending)
  );

  // Drop start and hold until every predicted cell is out and the walk is done
  task automatic drain_cells();
    start <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Present one register beat; the caller drops valid after its last beat
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_grid(int w, int h);
    write_reg(REG_GRID_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_GRID_HEIGHT, h[CFG_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one segment beat after a random gap; start stays high on return
  task automatic send_segment(int sx, int sy, int ex, int ey, int idle_pct);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    start_x <= sx[IN_W-1:0];
    start_y <= sy[IN_W-1:0];
    end_x   <= ex[IN_W-1:0];
    end_y   <= ey[IN_W-1:0];
    do @(posedge clk); while (busy);
  endtask

  function automatic int coord_between(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic int to_field(int v);
    if (v < -64) return -64;
    if (v > 63) return 63;
    return v;
  endfunction

  // Random segments: mostly in-grid, some clamped, some short
  task automatic run_phase(int items, int idle_pct);
    int kind, sx, sy, ex, ey;
    for (int i = 0; i < items; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        sx = coord_between(0, 63); sy = coord_between(0, 63);
        ex = coord_between(0, 63); ey = coord_between(0, 63);
      end else if (kind < 8) begin
        sx = coord_between(-64, 63); sy = coord_between(-64, 63);
        ex = coord_between(-64, 63); ey = coord_between(-64, 63);
      end else begin
        sx = coord_between(0, 63); sy = coord_between(0, 63);
        ex = to_field(sx + coord_between(-4, 4));
        ey = to_field(sy + coord_between(-4, 4));
      end
      send_segment(sx, sy, ex, ey, idle_pct);
      // now and then hold off until the block runs dry
      if ($urandom_range(0, 39) == 0) drain_cells();
    end
    drain_cells();
  endtask

  initial begin
    int widths[NUM_PHASES];
    int heights[NUM_PHASES];
    int idles[4];
    widths  = '{64, 1, 127, 0, 20, 0};
    heights = '{64, 1, 127, 5, 0, 0};
    idles   = '{0, 50, 0, 31};
    widths[NUM_PHASES-1]  = $urandom_range(0, 127);
    heights[NUM_PHASES-1] = $urandom_range(0, 127);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed segments on the reset grid
    send_segment(0, 0, 63, 0, 0);
    send_segment(5, 0, 5, 63, 0);
    send_segment(5, 63, 5, 0, 0);
    send_segment(0, 0, 63, 20, 0);
    send_segment(0, 0, 20, 63, 0);
    send_segment(0, 0, 63, 63, 0);
    send_segment(0, 63, 63, 0, 0);
    send_segment(10, 50, 40, 5, 0);
    send_segment(63, 10, 0, 40, 0);
    send_segment(10, 10, 10, 10, 0);
    send_segment(-5, -64, 0, 0, 0);
    send_segment(-64, -64, 63, 63, 0);
    send_segment(63, -64, -64, 63, 0);
    send_segment(-1, 3, -64, 40, 0);
    send_segment(-64, 3, -1, 40, 0);
    send_segment(3, -1, 3, -64, 0);
    send_segment(0, 0, 1, 0, 0);
    send_segment(0, 0, 1, 1, 0);
    send_segment(7, 7, 8, 30, 0);
    send_segment(62, 63, 63, 62, 0);
    send_segment(-1, -1, -1, -1, 0);
    drain_cells();

    // Spare indexes must leave the grid alone
    write_reg(REG_SPARE_A, 7'h7f);
    write_reg(REG_SPARE_B, 7'h00);
    cfg_valid <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_grid(widths[ph], heights[ph]);
      run_phase(PHASE_ITEMS, idles[ph % 4]);
    end

    drain_cells();
    if (fail_count == 0 && cells_pending == 0) begin
      $display("grid_line_rasterizer_core_tb: done, clean");
    end else begin
      $display("grid_line_rasterizer_core_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/glr_pkg.sv
rtl/glr_prep.sv
rtl/glr_walk.sv
rtl/grid_line_rasterizer_core.sv
rtl/glr_checker.sv
tb/sv/grid_line_rasterizer_core_checker.sv
tb/sv/grid_line_rasterizer_core_tb.sv
